// ===== hw/rtl/ccfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccfp_pkg: shared types and constants
// Widths, register indexes and the handshake structs between the sequencer
// and the symbol compare unit.
// ----------------------------------------------------------------------------
package ccfp_pkg;

  localparam int MAX_LEN = 62;
  localparam int LEN_W   = 6;   // holds any length, cut, period or symbol index
  localparam int REM_W   = 8;   // holds 2*MAX_LEN + MAX_LEN - 1
  localparam int CNT_W   = 3;   // copy count, saturates at COPY_CAP

  localparam logic [CNT_W-1:0] COPY_ONE  = 3'd1;
  localparam logic [CNT_W-1:0] COPY_TWO  = 3'd2;
  localparam logic [CNT_W-1:0] COPY_THREE = 3'd3;
  localparam logic [CNT_W-1:0] COPY_CAP  = 3'd4;

  // Register indexes, selected by paddr[2].
  localparam logic REG_WORD_LENGTH = 1'b0;
  localparam logic REG_PERIOD_CAP  = 1'b1;

  // One scan run of the compare unit.
  typedef struct packed {
    logic [LEN_W-1:0] pos_a;   // newer symbol position
    logic [LEN_W-1:0] pos_b;   // older symbol position
    logic [REM_W-1:0] rem;     // number of pairs that may be compared
    logic [LEN_W-1:0] per;     // block length for counting copies
  } scan_cmd_t;

  typedef struct packed {
    logic prim;
    logic fixed;
    logic squareful;
  } ccfp_result_t;

endpackage

// ===== hw/rtl/ccfp_scan.sv =====
// ----------------------------------------------------------------------------
// ccfp_scan: shared symbol compare unit
// Walks two positions of the cyclic word backwards, one symbol pair per
// cycle, and counts how many whole blocks of the given length repeat.
// ----------------------------------------------------------------------------
module ccfp_scan (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  ccfp_pkg::scan_cmd_t     cmd,
  input  logic [61:0]             word,
  input  logic [5:0]              len,
  output logic                    done,
  output logic [2:0]              copies
);
  import ccfp_pkg::*;

  logic             busy;
  logic [LEN_W-1:0] pos_a;
  logic [LEN_W-1:0] pos_b;
  logic [REM_W-1:0] rem;
  logic [LEN_W-1:0] per;
  logic [LEN_W-1:0] blk;

  logic             match;
  logic             blk_wrap;
  logic [LEN_W-1:0] pos_a_next;
  logic [LEN_W-1:0] pos_b_next;
  logic [REM_W-1:0] rem_next;
  logic [CNT_W-1:0] copies_next;
  logic             stop;

  always_comb begin
    match       = (word[pos_a] == word[pos_b]);
    pos_a_next  = (pos_a == '0) ? len - 6'd1 : pos_a - 6'd1;
    pos_b_next  = (pos_b == '0) ? len - 6'd1 : pos_b - 6'd1;
    rem_next    = rem - 8'd1;
    blk_wrap    = (blk == per - 6'd1);
    copies_next = blk_wrap ? copies + 3'd1 : copies;
    stop        = !match || (rem_next == '0) || (copies_next == COPY_CAP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && stop;
      if (start) begin
        busy   <= 1'b1;
        pos_a  <= cmd.pos_a;
        pos_b  <= cmd.pos_b;
        rem    <= cmd.rem;
        per    <= cmd.per;
        blk    <= '0;
        copies <= COPY_ONE;
      end else if (busy) begin
        if (match) begin
          pos_a  <= pos_a_next;
          pos_b  <= pos_b_next;
          rem    <= rem_next;
          blk    <= blk_wrap ? '0 : blk + 6'd1;
          copies <= copies_next;
        end
        if (stop) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ccfp_seq.sv =====
// ----------------------------------------------------------------------------
// ccfp_seq: sequencer
// Runs the primitivity check over all rotations, then the curling value of
// every cut over all periods up to the period cap, issuing one scan run at a time.
// ----------------------------------------------------------------------------
module ccfp_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [5:0]              word_length,
  input  logic [5:0]              period_cap,
  input  logic [61:0]             word,
  input  logic                    ack,
  output logic                    idle,
  output logic                    res_valid,
  output ccfp_pkg::ccfp_result_t  res,
  output logic                    scan_start,
  output ccfp_pkg::scan_cmd_t     scan_cmd,
  output logic [5:0]              len,
  input  logic                    scan_done,
  input  logic [2:0]              scan_copies
);
  import ccfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PRIM, S_PRIM_WAIT, S_CURL_INIT, S_CURL, S_CURL_WAIT, S_CUT_END, S_DONE
  } state_t;

  state_t           state;
  logic [LEN_W-1:0] cap;
  logic [LEN_W-1:0] per;
  logic [LEN_W-1:0] cut;
  logic [CNT_W-1:0] best;
  logic             prim;
  logic             fixed;
  logic             sqf;

  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] cap_eff;
  logic [LEN_W-1:0] curl_a;
  logic [LEN_W:0]   curl_b_wide;
  logic [REM_W-1:0] curl_rem;
  logic [CNT_W-1:0] best_next;
  logic [CNT_W-1:0] sym_val;
  logic             sqf_next;
  logic             fixed_next;

  always_comb begin
    if (word_length == '0) begin
      len_eff = 6'd1;
    end else if (word_length > 6'(MAX_LEN)) begin
      len_eff = 6'(MAX_LEN);
    end else begin
      len_eff = word_length;
    end
    cap_eff = (period_cap > len_eff - 6'd1) ? len_eff - 6'd1 : period_cap;

    // Last symbol of word,word,prefix(cut) sits at position cut-1 mod len.
    curl_a      = (cut == '0) ? len - 6'd1 : cut - 6'd1;
    curl_b_wide = (curl_a >= per) ? {1'b0, curl_a - per}
                                  : {1'b0, curl_a} + {1'b0, len} - {1'b0, per};
    curl_rem    = {1'b0, len, 1'b0} + {2'b00, cut} - {2'b00, per};

    best_next  = (scan_copies > best) ? scan_copies : best;
    sym_val    = {2'b01, word[cut]};
    sqf_next   = sqf && ((best == COPY_TWO) || (best == COPY_THREE));
    fixed_next = fixed && (best == sym_val);

    scan_start = (state == S_PRIM) || (state == S_CURL);
    if (state == S_PRIM) begin
      scan_cmd.pos_a = len - 6'd1;
      scan_cmd.pos_b = per - 6'd1;
      scan_cmd.rem   = {2'b00, len};
      scan_cmd.per   = len;
    end else begin
      scan_cmd.pos_a = curl_a;
      scan_cmd.pos_b = curl_b_wide[LEN_W-1:0];
      scan_cmd.rem   = curl_rem;
      scan_cmd.per   = per;
    end

    idle          = (state == S_IDLE);
    res_valid     = (state == S_DONE);
    res.prim      = prim;
    res.fixed     = fixed;
    res.squareful = sqf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            len   <= len_eff;
            cap   <= cap_eff;
            per   <= 6'd1;
            prim  <= 1'b1;
            fixed <= 1'b1;
            sqf   <= 1'b1;
            state <= (len_eff == 6'd1) ? S_CURL_INIT : S_PRIM;
          end
        end
        S_PRIM: begin
          state <= S_PRIM_WAIT;
        end
        S_PRIM_WAIT: begin
          if (scan_done) begin
            // A full pass of matches means the word equals this rotation.
            if (scan_copies == COPY_TWO) begin
              prim  <= 1'b0;
              state <= S_CURL_INIT;
            end else if (per == len - 6'd1) begin
              state <= S_CURL_INIT;
            end else begin
              per   <= per + 6'd1;
              state <= S_PRIM;
            end
          end
        end
        S_CURL_INIT: begin
          cut   <= '0;
          per   <= 6'd1;
          best  <= COPY_ONE;
          state <= (cap == '0) ? S_CUT_END : S_CURL;
        end
        S_CURL: begin
          state <= S_CURL_WAIT;
        end
        S_CURL_WAIT: begin
          if (scan_done) begin
            best <= best_next;
            if ((best_next == COPY_CAP) || (per == cap)) begin
              state <= S_CUT_END;
            end else begin
              per   <= per + 6'd1;
              state <= S_CURL;
            end
          end
        end
        S_CUT_END: begin
          sqf   <= sqf_next;
          fixed <= fixed_next;
          // Once both flags have failed nothing further can change them.
          if ((!sqf_next && !fixed_next) || (cut == len - 6'd1)) begin
            state <= S_DONE;
          end else begin
            cut   <= cut + 6'd1;
            per   <= 6'd1;
            best  <= COPY_ONE;
            state <= (cap == '0) ? S_CUT_END : S_CURL;
          end
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/cyclic_curling_fixed_point_check.sv =====
// ----------------------------------------------------------------------------
// cyclic_curling_fixed_point_check: top level
// Classifies one cyclic word of 2/3 symbols: primitive, curling fixed point,
// and squareful. Holds the configuration registers and the result register.
// ----------------------------------------------------------------------------
// One transaction at a time; the single compare unit sets the rate.
// A finished result waits in the output register while the next word is taken.
// Reset (synchronous, rst high): word_length = 62, period_cap = 61, block idle.
// ----------------------------------------------------------------------------
module cyclic_curling_fixed_point_check (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [61:0] word_bits,
  // Output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_primitive,
  output logic        is_fixed,
  output logic        is_squareful
);
  import ccfp_pkg::*;

  logic [LEN_W-1:0] word_length;
  logic [LEN_W-1:0] period_cap;
  logic [61:0]      word;

  logic             go;
  logic             seq_idle;
  logic             res_valid;
  ccfp_result_t     res;
  logic             ack;
  logic             scan_start;
  scan_cmd_t        scan_cmd;
  logic [LEN_W-1:0] len;
  logic             scan_done;
  logic [CNT_W-1:0] scan_copies;
  logic             cfg_wr;

  // The register is chosen by paddr[2]; the low address bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_PERIOD_CAP) ? {26'd0, period_cap} : {26'd0, word_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= 6'(MAX_LEN);
      period_cap  <= 6'(MAX_LEN - 1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WORD_LENGTH) begin
        word_length <= pwdata[LEN_W-1:0];
      end else begin
        period_cap <= pwdata[LEN_W-1:0];
      end
    end
  end

  // A new transaction is taken whenever the sequencer is idle, even while the
  // previous result still sits in the output register.
  assign in_ready = seq_idle;
  assign go       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (go) begin
      word <= word_bits;
    end
  end

  // The sequencer hands its result over once the output register is free.
  assign ack = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      is_primitive <= res.prim;
      is_fixed     <= res.fixed;
      is_squareful <= res.squareful;
    end
  end

  ccfp_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .word_length (word_length),
    .period_cap  (period_cap),
    .word        (word),
    .ack         (ack),
    .idle        (seq_idle),
    .res_valid   (res_valid),
    .res         (res),
    .scan_start  (scan_start),
    .scan_cmd    (scan_cmd),
    .len         (len),
    .scan_done   (scan_done),
    .scan_copies (scan_copies)
  );

  ccfp_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .cmd    (scan_cmd),
    .word   (word),
    .len    (len),
    .done   (scan_done),
    .copies (scan_copies)
  );

endmodule

// ===== tb/cyclic_curling_fixed_point_check_tb.sv =====
// ----------------------------------------------------------------------------
// cyclic_curling_fixed_point_check_tb: self-checking testbench
// Drives candidate words through the valid/ready input channel, predicts the
// primitive, fixed-point and squareful flags of every word in the testbench,
// and compares them in order with the results on the output channel while
// both sides idle and stall at random and the period cap and length change.
// ----------------------------------------------------------------------------
module cyclic_curling_fixed_point_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfp_pkg::*;

  typedef logic [61:0] word_t;

  // One outstanding word: the word itself, the settings it was taken under
  // and the flags it must produce.
  typedef struct {
    word_t            word;
    logic [5:0]       len_cfg;
    logic [5:0]       cap_cfg;
    ccfp_result_t     flags;
  } word_class_t;

  // Length of the long receiver hold-off used to fill the block up.
  localparam int LONG_HOLD_CYCLES = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  word_t       word_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_primitive;
  logic        is_fixed;
  logic        is_squareful;

  // Words waiting to be offered, and classifications waiting for a result.
  word_t       pending_words[$];
  word_class_t expected_classes[$];

  // Copy of the two registers as the block holds them. Only the register
  // write task changes them, and only while the block is idle.
  logic [5:0]  cfg_len = 6'd62;
  logic [5:0]  cfg_cap = 6'd61;

  // Idling controls, set by the stimulus process between phases.
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          hold_requested = 1'b0;
  int          hold_count = 0;

  logic        word_taken = 1'b0;
  int          mismatch_count = 0;
  int          words_checked = 0;
  int          settings_used = 0;
  int          nonprimitive_seen = 0;
  int          squareful_seen = 0;
  int          fixed_seen = 0;

  cyclic_curling_fixed_point_check u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .word_bits    (word_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_primitive (is_primitive),
    .is_fixed     (is_fixed),
    .is_squareful (is_squareful)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Classification of one word. Symbol i is 2 when bit i is clear and 3 when
  // it is set, so two symbols are equal exactly when their bits are equal.
  // The sequence word, word, first cut symbols is never built: its symbol k
  // is simply symbol k mod length of the word.
  // --------------------------------------------------------------------------
  function automatic ccfp_result_t classify_word(word_t bits, logic [5:0] len_cfg,
                                                 logic [5:0] cap_cfg);
    ccfp_result_t flags;
    int q, cap, n, best, copies, blk_end, blk_start, cut, p, i, j;
    bit power, same;
    q = int'(len_cfg);
    if (q < 1) q = 1;
    if (q > MAX_LEN) q = MAX_LEN;
    cap = int'(cap_cfg);
    flags.prim = 1'b1;
    flags.fixed = 1'b1;
    flags.squareful = 1'b1;

    // A word is a proper power when it repeats with some period that divides
    // its length.
    for (p = 1; p < q; p++) begin
      if (q % p == 0) begin
        power = 1'b1;
        for (i = p; i < q; i++)
          if (bits[i] != bits[i % p]) power = 1'b0;
        if (power) flags.prim = 1'b0;
      end
    end

    // For each cut, count how many equal blocks end the sequence for every
    // period allowed by the period cap, and keep the largest count.
    for (cut = 0; cut < q; cut++) begin
      n = 2 * q + cut;
      best = 1;
      for (p = 1; p < q && p <= cap; p++) begin
        copies = 1;
        blk_end = n - p;
        same = 1'b1;
        while (same && blk_end >= p) begin
          blk_start = blk_end - p;
          for (j = 0; j < p; j++)
            if (bits[(blk_start + j) % q] != bits[(n - p + j) % q]) same = 1'b0;
          if (same) begin
            copies++;
            blk_end = blk_start;
          end
        end
        if (copies > best) best = copies;
      end
      if (best < 2 || best > 3) flags.squareful = 1'b0;
      if (best != (bits[cut] ? 3 : 2)) flags.fixed = 1'b0;
    end
    return flags;
  endfunction

  // Random candidate word for a given length. Most words repeat a short
  // random block over the used bits, sometimes with one bit flipped, so that
  // long curling values, powers and near-powers come up often. The bits
  // above the length are always random, since the block has to ignore them.
  function automatic word_t make_word(int len);
    word_t w, blk;
    int q, per, flip;
    w = {$urandom, $urandom};
    q = (len < 1) ? 1 : ((len > MAX_LEN) ? MAX_LEN : len);
    if ($urandom_range(99) < 60) begin
      per = $urandom_range(1, (q > 1) ? q / 2 : 1);
      blk = {$urandom, $urandom};
      for (int i = 0; i < q; i++) w[i] = blk[i % per];
      if ($urandom_range(3) == 0) begin
        flip = $urandom_range(q - 1);
        w[flip] = ~w[flip];
      end
    end
    return w;
  endfunction

  // Appends one word to the queue of words still to be offered.
  task automatic add_word(word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver. A new word is offered only when the line is free or the
  // previous transaction was taken at the last rising edge, so valid never
  // drops while a word is still waiting. A random gap may be left between
  // transactions.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
        word_bits <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output ready. The long hold-off is counted here, in its own process;
  // after it the receiver stalls at random as set by stall_pct, like in the other phases.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_requested && hold_count < LONG_HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every accepted word is classified with the settings in force,
  // and every accepted result is compared with the oldest classification.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    word_class_t want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        want.word = word_bits;
        want.len_cfg = cfg_len;
        want.cap_cfg = cfg_cap;
        want.flags = classify_word(word_bits, cfg_len, cfg_cap);
        expected_classes.insert(expected_classes.size(), want);
      end
      if (out_valid && out_ready) begin
        if (expected_classes.size() == 0) begin
          flag_mismatch("result transaction with no word outstanding");
        end else begin
          want = expected_classes.pop_front();
          words_checked++;
          if (!want.flags.prim) nonprimitive_seen++;
          if (want.flags.squareful) squareful_seen++;
          if (want.flags.fixed) fixed_seen++;
          if (is_primitive !== want.flags.prim)
            flag_mismatch($sformatf("word %h len %0d cap %0d: is_primitive %b, expected %b",
                                    want.word, want.len_cfg, want.cap_cfg,
                                    is_primitive, want.flags.prim));
          if (is_fixed !== want.flags.fixed)
            flag_mismatch($sformatf("word %h len %0d cap %0d: is_fixed %b, expected %b",
                                    want.word, want.len_cfg, want.cap_cfg,
                                    is_fixed, want.flags.fixed));
          if (is_squareful !== want.flags.squareful)
            flag_mismatch($sformatf("word %h len %0d cap %0d: is_squareful %b, expected %b",
                                    want.word, want.len_cfg, want.cap_cfg,
                                    is_squareful, want.flags.squareful));
        end
      end
    end
  end

  // Waits until every queued word has been accepted and every result has
  // come back. The check runs just after the falling edge, once the drivers
  // have settled for that step.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_words.size() != 0 || in_valid || expected_classes.size() != 0);
  endtask

  // One register write: setup cycle, then access cycle until pready. The
  // bits above the six-bit field carry noise, which the block must drop.
  task automatic apb_write(logic reg_sel, logic [5:0] value);
    logic [31:0] data;
    data = $urandom;
    data[5:0] = value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_WORD_LENGTH) cfg_len = value;
    else cfg_cap = value;
  endtask

  task automatic set_config(logic [5:0] len, logic [5:0] cap);
    wait_drained();
    apb_write(REG_WORD_LENGTH, len);
    apb_write(REG_PERIOD_CAP, cap);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. A directed part walks the extremes and the special cases, then
  // random phases cycle through the idling patterns under changing settings,
  // and one phase holds the receiver off long enough to back the block up.
  // --------------------------------------------------------------------------
  initial begin
    int len, cap, seg;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, full length and full period cap: plain random words
    // only, since strongly repetitive words are slow at this size.
    settings_used++;
    repeat (2) add_word({$urandom, $urandom});

    // Full length with a small cap: all twos, all threes, alternating
    // symbols (a proper power) and a random word.
    set_config(6'd62, 6'd3);
    add_word('0);
    add_word('1);
    add_word(62'h1555_5555_5555_5555);
    add_word({$urandom, $urandom});

    // Length zero is taken as length one.
    set_config(6'd0, 6'd61);
    add_word('1);
    add_word('0);

    // Length above the maximum is clipped; a zero period cap tries no period.
    set_config(6'd63, 6'd0);
    add_word({$urandom, $urandom});
    add_word('1);

    // Period cap above length minus one is clipped as well.
    set_config(6'd63, 6'd63);
    add_word({$urandom, $urandom});

    // Short words: squares, cubes and primitive words, with the unused upper
    // bits both all ones and all zeros.
    set_config(6'd6, 6'd63);
    add_word(62'h3FFF_FFFF_FFFF_FFD5);
    add_word(62'h0000_0000_0000_0009);
    add_word(62'h2AAA_AAAA_AAAA_AA1B);
    add_word(62'h0000_0000_0000_0001);
    add_word(62'h0000_0000_0000_0034);
    add_word(62'h3FFF_FFFF_FFFF_FFC0);

    // Every word of length two.
    set_config(6'd2, 6'd1);
    for (int w = 0; w < 4; w++) add_word(word_t'(w));

    set_config(6'd5, 6'd2);
    repeat (2) add_word(make_word(5));

    // Random phases. The idling pattern cycles through none, sender gaps,
    // receiver stalls and both; one phase runs full length with a small cap.
    for (seg = 0; seg < 8; seg++) begin
      if (seg == 5) begin
        len = 62;
        cap = $urandom_range(1, 4);
      end else begin
        len = $urandom_range(1, 12);
        cap = ($urandom_range(3) == 0) ? 63 : $urandom_range(0, len);
      end
      set_config(6'(len), 6'(cap));
      case (seg % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      repeat (13) add_word(make_word(len));
    end

    // Back-pressure: the receiver holds off for a long stretch while words
    // keep coming, so a finished result sits in the output register and the
    // input channel has to stall.
    set_config(6'd8, 6'd7);
    gap_pct = 0;
    stall_pct = 0;
    hold_requested = 1'b1;
    repeat (12) add_word(make_word(8));

    wait_drained();
    // Any result that shows up now has no word behind it.
    repeat (50) @(negedge clk);

    $display("covered %0d words under %0d settings, lengths 1 to 62 and period caps 0 to 63",
             words_checked, settings_used);
    $display("seen %0d proper powers, %0d squareful words and %0d curling fixed points",
             nonprimitive_seen, squareful_seen, fixed_seen);
    if (mismatch_count == 0) begin
      $display("[cyclic_curling_fixed_point_check] OK");
    end else begin
      $display("[cyclic_curling_fixed_point_check] ERROR");
    end
    $finish;
  end

  // Watchdog, far above the slowest run the stimulus can produce.
  initial begin
    #200ms;
    $display("timeout at %0t ns with %0d results outstanding", $time, expected_classes.size());
    $display("[cyclic_curling_fixed_point_check] ERROR");
    $finish;
  end

endmodule
